FILE: design/izwm_pkg.sv
// constants, types and zoom lookup table for the integer zoom window magnifier
`default_nettype none

package izwm_pkg;

    localparam int FRAME_WIDTH  = 480;
    localparam int FRAME_HEIGHT = 320;
    localparam int MAX_ZOOM     = 15;
    localparam int MIN_ZOOM     = 2;

    localparam int POS_W   = 9;
    localparam int COLOR_W = 16;
    localparam int ZOOM_W  = 4;
    localparam int DATA_W  = 32;
    localparam int PADDR_W = 4;

    localparam int XW  = $clog2(FRAME_WIDTH);
    localparam int YW  = $clog2(FRAME_HEIGHT);
    localparam int PW  = (XW > YW) ? XW : YW;
    localparam int LXW = $clog2(FRAME_WIDTH + 1);
    localparam int LYW = $clog2(FRAME_HEIGHT + 1);
    localparam int SW  = ((PW > POS_W) ? PW : POS_W) + 2;

    localparam int RK        = PW + ZOOM_W;
    localparam int RECIP_W   = RK;
    localparam int RECIP_ONE = 1 << RK;

    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [POS_W-1:0]   FOCUS_X_RST = POS_W'(240);
    localparam logic [POS_W-1:0]   FOCUS_Y_RST = POS_W'(160);
    localparam logic [ZOOM_W-1:0]  ZOOM_RST    = ZOOM_W'(2);
    localparam logic [COLOR_W-1:0] BLACK       = '0;

    typedef enum logic [1:0] {
        REG_FOCUS_X,
        REG_FOCUS_Y,
        REG_ZOOM
    } t_reg_idx;

    typedef enum logic {
        OP_LOAD,
        OP_READ
    } t_opcode;

    typedef struct packed {
        logic [XW-1:0]      win_w;
        logic [YW-1:0]      win_h;
        logic [LXW-1:0]     lim_x;
        logic [LYW-1:0]     lim_y;
        logic [RECIP_W-1:0] recip;
    } t_zinfo;

    function automatic t_zinfo f_mk_zinfo(input int ww, input int wh, input int z,
                                          input int recip);
        t_zinfo f;
        f.win_w = XW'(ww);
        f.win_h = YW'(wh);
        f.lim_x = LXW'(ww * z);
        f.lim_y = LYW'(wh * z);
        f.recip = RECIP_W'(recip);
        return f;
    endfunction

    // window sizes, zoomed extents and ceil(2^RK / z) for each zoom
    function automatic t_zinfo f_zinfo(input logic [ZOOM_W-1:0] z);
        t_zinfo f;
        case (z)
            4'd3:  f = f_mk_zinfo(FRAME_WIDTH / 3, FRAME_HEIGHT / 3, 3, (RECIP_ONE + 2) / 3);
            4'd4:  f = f_mk_zinfo(FRAME_WIDTH / 4, FRAME_HEIGHT / 4, 4, (RECIP_ONE + 3) / 4);
            4'd5:  f = f_mk_zinfo(FRAME_WIDTH / 5, FRAME_HEIGHT / 5, 5, (RECIP_ONE + 4) / 5);
            4'd6:  f = f_mk_zinfo(FRAME_WIDTH / 6, FRAME_HEIGHT / 6, 6, (RECIP_ONE + 5) / 6);
            4'd7:  f = f_mk_zinfo(FRAME_WIDTH / 7, FRAME_HEIGHT / 7, 7, (RECIP_ONE + 6) / 7);
            4'd8:  f = f_mk_zinfo(FRAME_WIDTH / 8, FRAME_HEIGHT / 8, 8, (RECIP_ONE + 7) / 8);
            4'd9:  f = f_mk_zinfo(FRAME_WIDTH / 9, FRAME_HEIGHT / 9, 9, (RECIP_ONE + 8) / 9);
            4'd10: f = f_mk_zinfo(FRAME_WIDTH / 10, FRAME_HEIGHT / 10, 10,
                                  (RECIP_ONE + 9) / 10);
            4'd11: f = f_mk_zinfo(FRAME_WIDTH / 11, FRAME_HEIGHT / 11, 11,
                                  (RECIP_ONE + 10) / 11);
            4'd12: f = f_mk_zinfo(FRAME_WIDTH / 12, FRAME_HEIGHT / 12, 12,
                                  (RECIP_ONE + 11) / 12);
            4'd13: f = f_mk_zinfo(FRAME_WIDTH / 13, FRAME_HEIGHT / 13, 13,
                                  (RECIP_ONE + 12) / 13);
            4'd14: f = f_mk_zinfo(FRAME_WIDTH / 14, FRAME_HEIGHT / 14, 14,
                                  (RECIP_ONE + 13) / 14);
            4'd15: f = f_mk_zinfo(FRAME_WIDTH / 15, FRAME_HEIGHT / 15, 15,
                                  (RECIP_ONE + 14) / 15);
            default: f = f_mk_zinfo(FRAME_WIDTH / 2, FRAME_HEIGHT / 2, 2, (RECIP_ONE + 1) / 2);
        endcase
        return f;
    endfunction

endpackage

`default_nettype wire

FILE: design/integer_zoom_window_magnifier.sv
// integer zoom window magnifier: source frame store and zoom pipeline
//
// input channel (i_in_valid / o_in_ready): a load word (opcode 0) writes one
// RGB565 source pixel and gives no result; a read word (opcode 1) names a
// display pixel and gives one result word on the output channel
// (o_out_valid / i_out_ready) with its color and an inside-window flag.
// configuration: APB-style port, window center x at 0x0, center y at 0x4,
// zoom_factor at 0x8; pready is always high. the user must make writes only
// while idle; the block itself does not enforce it.
// throughput: one word per cycle unless the receiver stalls; the pipeline
// has input register, divide by reciprocal multiply, window offset add,
// address multiply, and one single-port memory access per word, with loads
// and reads in order.
// the source store is one 153600 x 16 single-port memory, undefined until
// loaded; there is no clearing pass.
// reset clears all valid bits and sets the registers to 240, 160 and 2.
// a stalled receiver holds the output word; bubbles collapse and the input
// stays ready until every stage is full.
`default_nettype none

module integer_zoom_window_magnifier (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  wire                            i_opcode,
    input  wire  [izwm_pkg::POS_W-1:0]     i_pos_x,
    input  wire  [izwm_pkg::POS_W-1:0]     i_pos_y,
    input  wire  [izwm_pkg::COLOR_W-1:0]   i_color,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output logic [izwm_pkg::COLOR_W-1:0]   o_pixel_color,
    output logic                           o_inside_window,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [izwm_pkg::PADDR_W-1:0]   paddr,
    input  wire  [izwm_pkg::DATA_W-1:0]    pwdata,
    output logic [izwm_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import izwm_pkg::*;

    // configuration registers
    logic [POS_W-1:0]  r_focus_x, n_focus_x;
    logic [POS_W-1:0]  r_focus_y, n_focus_y;
    logic [ZOOM_W-1:0] r_zoom, n_zoom;
    t_reg_idx          reg_idx;
    logic              cfg_wr;

    // derived window values
    logic [ZOOM_W-1:0]  zoom_eff;
    t_zinfo             zinfo;
    logic signed [SW-1:0] sx_raw, sx_max, sy_raw, sy_max;
    logic [XW-1:0]      start_x;
    logic [YW-1:0]      start_y;
    logic [XW-1:0]      r_start_x;
    logic [YW-1:0]      r_start_y;
    logic [LXW-1:0]     r_lim_x;
    logic [LYW-1:0]     r_lim_y;
    logic [RECIP_W-1:0] r_recip;

    // pipeline
    logic ready2, ready3, ready4, ready5, out_ready;

    logic               r_s1_valid;
    t_opcode            r_s1_op;
    logic               r_s1_ok;
    logic [XW-1:0]      r_s1_x;
    logic [YW-1:0]      r_s1_y;
    logic [COLOR_W-1:0] r_s1_color;

    logic                  r_s2_valid;
    t_opcode               r_s2_op;
    logic                  r_s2_ok;
    logic                  r_s2_in_zoom;
    logic [XW-1:0]         r_s2_x;
    logic [YW-1:0]         r_s2_y;
    logic [COLOR_W-1:0]    r_s2_color;
    logic [XW+RK-1:0]      r_s2_px;
    logic [YW+RK-1:0]      r_s2_py;

    logic               r_s3_valid;
    t_opcode            r_s3_op;
    logic               r_s3_ok;
    logic [XW-1:0]      r_s3_x;
    logic [YW-1:0]      r_s3_y;
    logic [COLOR_W-1:0] r_s3_color;

    logic               r_s4_valid;
    t_opcode            r_s4_op;
    logic               r_s4_ok;
    logic [AW-1:0]      r_s4_addr;
    logic [COLOR_W-1:0] r_s4_color;

    logic               r_s5_valid;
    t_opcode            r_s5_op;
    logic               r_s5_ok;
    logic [COLOR_W-1:0] r_s5_rd;

    logic               r_out_valid;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_inside;

    logic [COLOR_W-1:0] mem [DEPTH];

    // configuration port
    assign reg_idx = t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_comb begin
        n_focus_x = r_focus_x;
        n_focus_y = r_focus_y;
        n_zoom    = r_zoom;
        if (cfg_wr) begin
            case (reg_idx)
                REG_FOCUS_X: n_focus_x = pwdata[POS_W-1:0];
                REG_FOCUS_Y: n_focus_y = pwdata[POS_W-1:0];
                REG_ZOOM:    n_zoom    = pwdata[ZOOM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_FOCUS_X: prdata = DATA_W'(r_focus_x);
            REG_FOCUS_Y: prdata = DATA_W'(r_focus_y);
            REG_ZOOM:    prdata = DATA_W'(r_zoom);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focus_x <= FOCUS_X_RST;
            r_focus_y <= FOCUS_Y_RST;
            r_zoom    <= ZOOM_RST;
        end else begin
            r_focus_x <= n_focus_x;
            r_focus_y <= n_focus_y;
            r_zoom    <= n_zoom;
        end
    end

    // window values follow the next register values, so they match them
    always_comb begin
        if (32'(n_zoom) < MIN_ZOOM) begin
            zoom_eff = ZOOM_W'(MIN_ZOOM);
        end else if (32'(n_zoom) > MAX_ZOOM) begin
            zoom_eff = ZOOM_W'(MAX_ZOOM);
        end else begin
            zoom_eff = n_zoom;
        end
        zinfo  = f_zinfo(zoom_eff);
        sx_raw = $signed(SW'(n_focus_x)) - $signed(SW'(zinfo.win_w >> 1));
        sx_max = $signed(SW'(FRAME_WIDTH)) - $signed(SW'(zinfo.win_w));
        sy_raw = $signed(SW'(n_focus_y)) - $signed(SW'(zinfo.win_h >> 1));
        sy_max = $signed(SW'(FRAME_HEIGHT)) - $signed(SW'(zinfo.win_h));
        if (sx_raw < 0) begin
            start_x = '0;
        end else if (sx_raw >= sx_max) begin
            start_x = XW'(sx_max);
        end else begin
            start_x = XW'(sx_raw);
        end
        if (sy_raw < 0) begin
            start_y = '0;
        end else if (sy_raw >= sy_max) begin
            start_y = YW'(sy_max);
        end else begin
            start_y = YW'(sy_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        r_start_x <= start_x;
        r_start_y <= start_y;
        r_lim_x   <= zinfo.lim_x;
        r_lim_y   <= zinfo.lim_y;
        r_recip   <= zinfo.recip;
    end

    // stage handshake
    assign out_ready  = ~r_out_valid | i_out_ready;
    assign ready5     = ~r_s5_valid | (r_s5_op == OP_LOAD) | out_ready;
    assign ready4     = ~r_s4_valid | ready5;
    assign ready3     = ~r_s3_valid | ready4;
    assign ready2     = ~r_s2_valid | ready3;
    assign o_in_ready = ~r_s1_valid | ready2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_s5_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (ready2) begin
                r_s2_valid <= r_s1_valid;
            end
            if (ready3) begin
                r_s3_valid <= r_s2_valid;
            end
            if (ready4) begin
                r_s4_valid <= r_s3_valid;
            end
            if (ready5) begin
                r_s5_valid <= r_s4_valid;
            end
            if (out_ready) begin
                r_out_valid <= r_s5_valid & (r_s5_op == OP_READ);
            end
        end
    end

    // input register with frame check
    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_s1_op    <= t_opcode'(i_opcode);
            r_s1_ok    <= (32'(i_pos_x) < FRAME_WIDTH) && (32'(i_pos_y) < FRAME_HEIGHT);
            r_s1_x     <= XW'(i_pos_x);
            r_s1_y     <= YW'(i_pos_y);
            r_s1_color <= i_color;
        end
    end

    // reciprocal multiply and zoomed area check
    always_ff @(posedge i_clk) begin
        if (ready2) begin
            r_s2_op      <= r_s1_op;
            r_s2_ok      <= r_s1_ok;
            r_s2_in_zoom <= (LXW'(r_s1_x) < r_lim_x) && (LYW'(r_s1_y) < r_lim_y);
            r_s2_x       <= r_s1_x;
            r_s2_y       <= r_s1_y;
            r_s2_color   <= r_s1_color;
            r_s2_px      <= (XW+RK)'(r_s1_x) * (XW+RK)'(r_recip);
            r_s2_py      <= (YW+RK)'(r_s1_y) * (YW+RK)'(r_recip);
        end
    end

    // source coordinate
    always_ff @(posedge i_clk) begin
        if (ready3) begin
            r_s3_op    <= r_s2_op;
            r_s3_color <= r_s2_color;
            if (r_s2_op == OP_READ) begin
                r_s3_ok <= r_s2_ok & r_s2_in_zoom;
                r_s3_x  <= r_start_x + r_s2_px[RK +: XW];
                r_s3_y  <= r_start_y + r_s2_py[RK +: YW];
            end else begin
                r_s3_ok <= r_s2_ok;
                r_s3_x  <= r_s2_x;
                r_s3_y  <= r_s2_y;
            end
        end
    end

    // store address
    always_ff @(posedge i_clk) begin
        if (ready4) begin
            r_s4_op    <= r_s3_op;
            r_s4_ok    <= r_s3_ok;
            r_s4_color <= r_s3_color;
            r_s4_addr  <= AW'(AW'(r_s3_y) * AW'(FRAME_WIDTH)) + AW'(r_s3_x);
        end
    end

    // source store access
    always_ff @(posedge i_clk) begin
        if (ready5 && r_s4_valid && r_s4_ok && (r_s4_op == OP_LOAD)) begin
            mem[r_s4_addr] <= r_s4_color;
        end
        if (ready5) begin
            r_s5_rd <= mem[r_s4_addr];
            r_s5_op <= r_s4_op;
            r_s5_ok <= r_s4_ok;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (out_ready) begin
            r_out_color  <= r_s5_ok ? r_s5_rd : BLACK;
            r_out_inside <= r_s5_ok;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_pixel_color   = r_out_color;
    assign o_inside_window = r_out_inside;

endmodule

`default_nettype wire
